// ===== sv/bbs_pkg.sv =====
// Shared constants, types and controller/datapath links for the broadcast schedule block.
`timescale 1ns / 1ps
`default_nettype none
package bbs_pkg;

    localparam int MAX_RANKS  = 1024;
    localparam int RANK_W     = 10;
    localparam int GS_W       = 11;
    localparam int BYTES_W    = 31;
    localparam int LVL_W      = 4;
    localparam int DIV_W      = 32;
    localparam int CNT_W      = $clog2(DIV_W);
    localparam int PROD_W     = BYTES_W + GS_W;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic REG_GROUP_SIZE = 1'b0;
    localparam logic REG_OWN_RANK   = 1'b1;

    localparam logic OP_RECV = 1'b0;
    localparam logic OP_SEND = 1'b1;

    localparam logic REQ_WHOLE   = 1'b0;
    localparam logic REQ_SCATTER = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV,
        ST_RMUL_LO,
        ST_RMUL_HI,
        ST_REMIT,
        ST_SMUL,
        ST_SEMIT,
        ST_FLUSH
    } state_t;

    typedef struct packed {
        logic                   req_type;
        logic [RANK_W-1:0]      root_rank;
        logic [BYTES_W-1:0]     message_bytes;
    } req_t;

    typedef struct packed {
        logic                   op_kind;
        logic [RANK_W-1:0]      peer_rank;
        logic [BYTES_W-1:0]     byte_offset;
        logic [BYTES_W-1:0]     byte_length;
        logic                   last_op;
    } op_t;

    typedef struct packed {
        logic load;
        logic init;
        logic div_step;
        logic mul_start;
        logic mul_end;
        logic mul_send;
        logic recv_emit;
        logic send_emit;
        logic flush;
    } ctrl_cmd_t;

    typedef struct packed {
        logic trivial;
        logic is_root;
        logic div_last;
        logic lvl_zero;
        logic lvl_last;
        logic recv_has_op;
        logic send_has_op;
        logic pend_valid;
        logic out_free;
    } ctrl_stat_t;

endpackage
`default_nettype wire

// ===== sv/bbs_if.sv =====
// Request and operation channel interfaces.
`timescale 1ns / 1ps
`default_nettype none
interface bbs_in_if import bbs_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic                   req_type;
    logic [RANK_W-1:0]      root_rank;
    logic [BYTES_W-1:0]     message_bytes;

    modport source (output valid, output req_type, output root_rank, output message_bytes,
                    input ready);
    modport sink   (input valid, input req_type, input root_rank, input message_bytes,
                    output ready);
endinterface

interface bbs_out_if import bbs_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic                   op_kind;
    logic [RANK_W-1:0]      peer_rank;
    logic [BYTES_W-1:0]     byte_offset;
    logic [BYTES_W-1:0]     byte_length;
    logic                   last_op;

    modport source (output valid, output op_kind, output peer_rank, output byte_offset,
                    output byte_length, output last_op, input ready);
    modport sink   (input valid, input op_kind, input peer_rank, input byte_offset,
                    input byte_length, input last_op, output ready);
endinterface
`default_nettype wire

// ===== sv/binomial_broadcast_schedule_core.sv =====
// Binomial-tree broadcast schedule generator, top level.
//
// Requests arrive on in_ch (req_type, root_rank, message_bytes) with valid/ready;
// operations leave on out_ch, one item per transfer, in tree order: the receive
// from the parent first (non-root ranks), then sends to children, largest mask
// first. last_op marks the final operation of a request; a request that yields
// no operation produces no item.
// group_size and own_rank are set through the APB port (byte addresses 0 and 4)
// and must only change while no request is in flight.
// Sequence: one request is worked at a time. Load and check come first, then the
// chunk divider runs (one quotient bit per cycle), then the receive (start and
// end multiplies, then emit) and each tree level (multiply, then emit), and a
// flush step releases the final operation; the root skips the receive. Trivial
// requests return to idle after the check.
// The output register and a one-deep pending stage hold operations; a stall on
// out_ch holds the walk at the next emit step. A new request is taken as soon as
// the last operation is in the output register.
// Reset returns group_size to 1, own_rank to 0 and empties all stages.
`timescale 1ns / 1ps
`default_nettype none
module binomial_broadcast_schedule_core import bbs_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    bbs_in_if.sink                      in_ch,
    bbs_out_if.source                   out_ch,
    input  wire logic                   psel,
    input  wire logic                   penable,
    input  wire logic                   pwrite,
    input  wire logic [CFG_ADDR_W-1:0]  paddr,
    input  wire logic [CFG_DATA_W-1:0]  pwdata,
    output      logic [CFG_DATA_W-1:0]  prdata,
    output      logic                   pready
);

    logic [GS_W-1:0]   group_size;
    logic [RANK_W-1:0] own_rank;
    req_t              req;
    ctrl_cmd_t         cmd;
    ctrl_stat_t        stat;
    logic              out_valid;
    op_t               out_op;
    logic              in_ready;

    assign req.req_type      = in_ch.req_type;
    assign req.root_rank     = in_ch.root_rank;
    assign req.message_bytes = in_ch.message_bytes;
    assign in_ch.ready       = in_ready;

    bbs_cfg u_cfg (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .group_size (group_size),
        .own_rank   (own_rank)
    );

    bbs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    bbs_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .group_size (group_size),
        .own_rank   (own_rank),
        .req        (req),
        .cmd        (cmd),
        .stat       (stat),
        .out_ready  (out_ch.ready),
        .out_valid  (out_valid),
        .out_op     (out_op)
    );

    assign out_ch.valid       = out_valid;
    assign out_ch.op_kind     = out_op.op_kind;
    assign out_ch.peer_rank   = out_op.peer_rank;
    assign out_ch.byte_offset = out_op.byte_offset;
    assign out_ch.byte_length = out_op.byte_length;
    assign out_ch.last_op     = out_op.last_op;

endmodule
`default_nettype wire

// ===== sv/bbs_cfg.sv =====
// APB configuration registers: group size and own rank.
`timescale 1ns / 1ps
`default_nettype none
module bbs_cfg import bbs_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   psel,
    input  wire logic                   penable,
    input  wire logic                   pwrite,
    input  wire logic [CFG_ADDR_W-1:0]  paddr,
    input  wire logic [CFG_DATA_W-1:0]  pwdata,
    output      logic [CFG_DATA_W-1:0]  prdata,
    output      logic                   pready,
    output      logic [GS_W-1:0]        group_size,
    output      logic [RANK_W-1:0]      own_rank
);

    logic [GS_W-1:0]   group_size_reg, group_size_next;
    logic [RANK_W-1:0] own_rank_reg, own_rank_next;
    logic              reg_idx;
    logic              wr_en;

    assign reg_idx = paddr[CFG_ADDR_W-1];
    assign wr_en   = psel & penable & pwrite;
    assign pready  = 1'b1;

    always_comb
    begin
        group_size_next = group_size_reg;
        own_rank_next   = own_rank_reg;
        if (wr_en)
        begin
            unique case (reg_idx)
                REG_GROUP_SIZE: group_size_next = pwdata[GS_W-1:0];
                REG_OWN_RANK:   own_rank_next   = pwdata[RANK_W-1:0];
                default:        group_size_next = group_size_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_GROUP_SIZE: prdata = CFG_DATA_W'(group_size_reg);
            REG_OWN_RANK:   prdata = CFG_DATA_W'(own_rank_reg);
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            group_size_reg <= GS_W'(1);
            own_rank_reg   <= '0;
        end
        else
        begin
            group_size_reg <= group_size_next;
            own_rank_reg   <= own_rank_next;
        end
    end

    assign group_size = group_size_reg;
    assign own_rank   = own_rank_reg;

endmodule
`default_nettype wire

// ===== sv/bbs_ctrl.sv =====
// Schedule controller: sequences load, divide, receive and send steps.
`timescale 1ns / 1ps
`default_nettype none
module bbs_ctrl import bbs_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output      logic       in_ready,
    input  wire ctrl_stat_t stat,
    output      ctrl_cmd_t  cmd
);

    state_t state_reg, state_next;
    logic   recv_go;
    logic   send_go;
    logic   flush_go;

    assign recv_go  = !(stat.recv_has_op && stat.pend_valid && !stat.out_free);
    assign send_go  = !(stat.send_has_op && stat.pend_valid && !stat.out_free);
    assign flush_go = !stat.pend_valid || stat.out_free;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:    if (in_valid) state_next = ST_CHECK;
            ST_CHECK:   state_next = stat.trivial ? ST_IDLE : ST_DIV;
            ST_DIV:
            begin
                if (stat.div_last)
                    state_next = stat.is_root ? ST_SMUL : ST_RMUL_LO;
            end
            ST_RMUL_LO: state_next = ST_RMUL_HI;
            ST_RMUL_HI: state_next = ST_REMIT;
            ST_REMIT:
            begin
                if (recv_go)
                    state_next = stat.lvl_zero ? ST_FLUSH : ST_SMUL;
            end
            ST_SMUL:    state_next = ST_SEMIT;
            ST_SEMIT:
            begin
                if (send_go)
                    state_next = stat.lvl_last ? ST_FLUSH : ST_SMUL;
            end
            ST_FLUSH:   if (flush_go) state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_CHECK:   cmd.init      = !stat.trivial;
            ST_DIV:     cmd.div_step  = 1'b1;
            ST_RMUL_LO: cmd.mul_start = 1'b1;
            ST_RMUL_HI: cmd.mul_end   = 1'b1;
            ST_REMIT:   cmd.recv_emit = recv_go;
            ST_SMUL:    cmd.mul_send  = 1'b1;
            ST_SEMIT:   cmd.send_emit = send_go;
            ST_FLUSH:   cmd.flush     = flush_go;
            default:    cmd           = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule
`default_nettype wire

// ===== sv/bbs_dp.sv =====
// Schedule datapath: chunk divider, offset multiplier, tree walk and output staging.
`timescale 1ns / 1ps
`default_nettype none
module bbs_dp import bbs_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic [GS_W-1:0]   group_size,
    input  wire logic [RANK_W-1:0] own_rank,
    input  wire req_t              req,
    input  wire ctrl_cmd_t         cmd,
    output      ctrl_stat_t        stat,
    input  wire logic              out_ready,
    output      logic              out_valid,
    output      op_t               out_op
);

    // smallest level whose power of two reaches n
    function automatic logic [LVL_W-1:0] lvl_ceil(input logic [GS_W-1:0] n);
        logic [LVL_W-1:0] res;
        logic [GS_W:0]    pw;
        res = LVL_W'(GS_W);
        for (int i = GS_W - 1; i >= 0; i--)
        begin
            pw = (GS_W+1)'(1) << i;
            if (pw >= {1'b0, n})
                res = LVL_W'(i);
        end
        return res;
    endfunction

    // position of lowest set bit
    function automatic logic [LVL_W-1:0] low_bit(input logic [RANK_W-1:0] v);
        logic [LVL_W-1:0] res;
        res = '0;
        for (int i = RANK_W - 1; i >= 0; i--)
        begin
            if (v[i])
                res = LVL_W'(i);
        end
        return res;
    endfunction

    logic                   scatter_reg, scatter_next;
    logic [RANK_W-1:0]      root_reg, root_next;
    logic [BYTES_W-1:0]     nbytes_reg, nbytes_next;
    logic [RANK_W-1:0]      r_reg, r_next;
    logic [LVL_W-1:0]       lvl_reg, lvl_next;
    logic [GS_W-1:0]        rem_reg, rem_next;
    logic [DIV_W-1:0]       quo_reg, quo_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic [PROD_W-1:0]      start_reg, start_next;
    logic [PROD_W-1:0]      prod_reg, prod_next;
    logic [BYTES_W-1:0]     curr_reg, curr_next;
    op_t                    pend_reg, pend_next;
    logic                   pend_valid_reg, pend_valid_next;
    op_t                    out_reg, out_next;
    logic                   out_valid_reg, out_valid_next;

    logic [GS_W-1:0]        n_eff;
    logic [GS_W-1:0]        rank_ext;
    logic [GS_W-1:0]        root_ext;
    logic                   is_root;
    logic [RANK_W-1:0]      r_init;
    logic [DIV_W-1:0]       dividend;
    logic [GS_W:0]          div_trial;
    logic                   div_ge;
    logic [BYTES_W-1:0]     chunk;
    logic [LVL_W-1:0]       lvl_dec;
    logic [GS_W-1:0]        m_cur;
    logic [GS_W-1:0]        cm;
    logic [GS_W-1:0]        child_rel;
    logic [GS_W-1:0]        dst_sum;
    logic [GS_W-1:0]        dst;
    logic [GS_W-1:0]        src;
    logic [GS_W-1:0]        mul_b;
    logic [PROD_W-1:0]      prod;
    logic [PROD_W-1:0]      nb_ext;
    logic                   start_lt;
    logic [PROD_W-1:0]      end_min;
    logic [BYTES_W-1:0]     recv_len;
    logic [PROD_W-1:0]      keep;
    logic                   curr_gt;
    logic                   recv_has_op;
    logic                   send_has_op;
    op_t                    recv_op;
    op_t                    send_op;
    op_t                    new_op;
    logic                   new_has_op;
    logic                   out_free;

    assign n_eff    = (group_size > GS_W'(MAX_RANKS)) ? GS_W'(MAX_RANKS) : group_size;
    assign rank_ext = {1'b0, own_rank};
    assign root_ext = {1'b0, root_reg};
    assign is_root  = (own_rank == root_reg);
    assign r_init   = (rank_ext >= root_ext) ? RANK_W'(rank_ext - root_ext)
                                             : RANK_W'(rank_ext + n_eff - root_ext);
    assign dividend = DIV_W'(nbytes_reg) + DIV_W'(n_eff) - DIV_W'(1);

    assign div_trial = {rem_reg, quo_reg[DIV_W-1]};
    assign div_ge    = div_trial >= {1'b0, n_eff};
    assign chunk     = quo_reg[BYTES_W-1:0];

    assign lvl_dec   = lvl_reg - LVL_W'(1);
    assign m_cur     = GS_W'(1) << lvl_reg;
    assign cm        = GS_W'(1) << lvl_dec;
    assign child_rel = {1'b0, r_reg} + cm;
    assign dst_sum   = rank_ext + cm;
    assign dst       = (dst_sum >= n_eff) ? dst_sum - n_eff : dst_sum;
    assign src       = (rank_ext >= m_cur) ? rank_ext - m_cur : rank_ext + n_eff - m_cur;

    always_comb
    begin
        mul_b = {1'b0, r_reg};
        if (cmd.mul_end)
            mul_b = {1'b0, r_reg} + m_cur;
        else if (cmd.mul_send)
            mul_b = child_rel;
    end

    assign prod = PROD_W'(chunk) * PROD_W'(mul_b);

    assign nb_ext   = PROD_W'(nbytes_reg);
    assign start_lt = start_reg < nb_ext;
    assign end_min  = (prod_reg > nb_ext) ? nb_ext : prod_reg;
    assign recv_len = BYTES_W'(end_min - start_reg);
    assign keep     = PROD_W'(chunk) << lvl_dec;
    assign curr_gt  = PROD_W'(curr_reg) > keep;

    assign recv_has_op = (scatter_reg == REQ_WHOLE) || start_lt;
    assign send_has_op = (child_rel < n_eff) && ((scatter_reg == REQ_WHOLE) || curr_gt);

    always_comb
    begin
        recv_op.op_kind     = OP_RECV;
        recv_op.peer_rank   = src[RANK_W-1:0];
        recv_op.byte_offset = scatter_reg ? start_reg[BYTES_W-1:0] : '0;
        recv_op.byte_length = scatter_reg ? recv_len : nbytes_reg;
        recv_op.last_op     = 1'b0;

        send_op.op_kind     = OP_SEND;
        send_op.peer_rank   = dst[RANK_W-1:0];
        send_op.byte_offset = scatter_reg ? prod_reg[BYTES_W-1:0] : '0;
        send_op.byte_length = scatter_reg ? curr_reg - keep[BYTES_W-1:0] : nbytes_reg;
        send_op.last_op     = 1'b0;

        new_op     = cmd.recv_emit ? recv_op : send_op;
        new_has_op = (cmd.recv_emit && recv_has_op) || (cmd.send_emit && send_has_op);
    end

    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        scatter_next    = scatter_reg;
        root_next       = root_reg;
        nbytes_next     = nbytes_reg;
        r_next          = r_reg;
        lvl_next        = lvl_reg;
        rem_next        = rem_reg;
        quo_next        = quo_reg;
        cnt_next        = cnt_reg;
        start_next      = start_reg;
        prod_next       = prod_reg;
        curr_next       = curr_reg;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg && !out_ready;

        if (cmd.load)
        begin
            scatter_next = req.req_type;
            root_next    = req.root_rank;
            nbytes_next  = req.message_bytes;
        end

        if (cmd.init)
        begin
            r_next    = r_init;
            lvl_next  = is_root ? lvl_ceil(n_eff) : low_bit(r_init);
            rem_next  = '0;
            quo_next  = dividend;
            cnt_next  = '0;
            curr_next = is_root ? nbytes_reg : '0;
        end

        if (cmd.div_step)
        begin
            rem_next = div_ge ? GS_W'(div_trial - {1'b0, n_eff}) : div_trial[GS_W-1:0];
            quo_next = {quo_reg[DIV_W-2:0], div_ge};
            cnt_next = cnt_reg + CNT_W'(1);
        end

        if (cmd.mul_start)
            start_next = prod;
        if (cmd.mul_end || cmd.mul_send)
            prod_next = prod;

        if (cmd.recv_emit && scatter_reg)
            curr_next = start_lt ? recv_len : '0;

        if (cmd.send_emit)
        begin
            lvl_next = lvl_dec;
            if (send_has_op && scatter_reg)
                curr_next = keep[BYTES_W-1:0];
        end

        if (new_has_op)
        begin
            if (pend_valid_reg)
            begin
                out_next       = pend_reg;
                out_valid_next = 1'b1;
            end
            pend_next       = new_op;
            pend_valid_next = 1'b1;
        end

        if (cmd.flush && pend_valid_reg)
        begin
            out_next         = pend_reg;
            out_next.last_op = 1'b1;
            out_valid_next   = 1'b1;
            pend_valid_next  = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        scatter_reg <= scatter_next;
        root_reg    <= root_next;
        nbytes_reg  <= nbytes_next;
        r_reg       <= r_next;
        lvl_reg     <= lvl_next;
        rem_reg     <= rem_next;
        quo_reg     <= quo_next;
        cnt_reg     <= cnt_next;
        start_reg   <= start_next;
        prod_reg    <= prod_next;
        curr_reg    <= curr_next;
        pend_reg    <= pend_next;
        out_reg     <= out_next;
    end

    always_comb
    begin
        stat.trivial     = (n_eff <= GS_W'(1)) || (nbytes_reg == '0)
                           || (rank_ext >= n_eff) || (root_ext >= n_eff);
        stat.is_root     = is_root;
        stat.div_last    = (cnt_reg == {CNT_W{1'b1}});
        stat.lvl_zero    = (lvl_reg == '0);
        stat.lvl_last    = (lvl_reg == LVL_W'(1));
        stat.recv_has_op = recv_has_op;
        stat.send_has_op = send_has_op;
        stat.pend_valid  = pend_valid_reg;
        stat.out_free    = out_free;
    end

    assign out_valid = out_valid_reg;
    assign out_op    = out_reg;

endmodule
`default_nettype wire
